@@ hdl/bcc_pkg.sv @@
// package for the button click classifier: mode encoding, register indexes,
// reset values, stream widths and the config/result structs
// no dependencies

package bcc_pkg;

   localparam int TIME_BITS_DEFAULT = 32;
   localparam int NOW_BITS          = 32;
   localparam int DELAY_BITS        = 16;
   localparam int COUNT_BITS        = 8;
   localparam int MODE_BITS         = 3;
   localparam int CSR_INDEX_BITS    = 2;

   localparam int REQ_TDATA_BITS = 40;   // 1 + 32 packed, padded to bytes
   localparam int RSP_TDATA_BITS = 24;   // 17 packed, padded to bytes

   localparam logic [COUNT_BITS-1:0] CLICK_MAX = COUNT_BITS'(255);

   localparam logic                  ACTIVE_LEVEL_RESET = 1'b0;
   localparam logic [DELAY_BITS-1:0] DEBOUNCE_RESET     = DELAY_BITS'(50);
   localparam logic [DELAY_BITS-1:0] CLICK_WINDOW_RESET = DELAY_BITS'(300);
   localparam logic [DELAY_BITS-1:0] LONG_PRESS_RESET   = DELAY_BITS'(1000);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_WINDOW = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS   = 2'd3;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_IDLE       = 3'd0,
      MODE_DEBOUNCING = 3'd1,
      MODE_PRESSED    = 3'd2,
      MODE_CLICKED    = 3'd3,
      MODE_RELEASED   = 3'd4,
      MODE_LONG       = 3'd5
   } bcc_mode_type;

   typedef struct packed {
      logic                  active_level;
      logic [DELAY_BITS-1:0] debounce_ms;
      logic [DELAY_BITS-1:0] click_window_ms;
      logic [DELAY_BITS-1:0] long_press_ms;
   } bcc_cfg_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode_code;
      logic                  held_now;
      logic                  long_release_event;
      logic                  long_press_event;
      logic                  release_event;
      logic                  press_event;
      logic [COUNT_BITS-1:0] click_total;
      logic                  click_event;
   } bcc_result_type;

endpackage

@@ hdl/bcc_csr.sv @@
// configuration registers of the button click classifier
// depends on bcc_pkg

module bcc_csr
   import bcc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DELAY_BITS-1:0]     csr_data,
   output bcc_cfg_type               cfg
);

   bcc_cfg_type cfg_ff;
   bcc_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL: cfg_in.active_level    = csr_data[0];
            CSR_DEBOUNCE:     cfg_in.debounce_ms     = csr_data;
            CSR_CLICK_WINDOW: cfg_in.click_window_ms = csr_data;
            CSR_LONG_PRESS:   cfg_in.long_press_ms   = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level    <= ACTIVE_LEVEL_RESET;
         cfg_ff.debounce_ms     <= DEBOUNCE_RESET;
         cfg_ff.click_window_ms <= CLICK_WINDOW_RESET;
         cfg_ff.long_press_ms   <= LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hdl/bcc_core.sv @@
// button state machine: debounce, click counting and long press detection,
// updates its state on advance and gives the result of that poll
// depends on bcc_pkg

module bcc_core
   import bcc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 pin_level,
   input  logic [TIME_BITS-1:0] now_ms,
   input  bcc_cfg_type          cfg,
   output bcc_result_type       result
);

   bcc_mode_type          mode_ff, mode_in;
   logic [COUNT_BITS-1:0] click_counter_ff, click_counter_in;
   logic [TIME_BITS-1:0]  debounce_start_ff, debounce_start_in;
   logic [TIME_BITS-1:0]  press_start_ff, press_start_in;
   logic [TIME_BITS-1:0]  last_click_ff, last_click_in;

   logic                  down;
   logic                  debounce_passed;
   logic                  window_passed;
   logic                  long_passed;
   logic                  entered;

   assign down = (pin_level == cfg.active_level);

   // wrapping elapsed time, strictly greater than the delay
   assign debounce_passed = (now_ms - debounce_start_ff) > TIME_BITS'(cfg.debounce_ms);
   assign window_passed   = (now_ms - last_click_ff) > TIME_BITS'(cfg.click_window_ms);
   assign long_passed     = (now_ms - press_start_ff) > TIME_BITS'(cfg.long_press_ms);

   // next state
   always_comb begin
      mode_in           = mode_ff;
      click_counter_in  = click_counter_ff;
      debounce_start_in = debounce_start_ff;
      press_start_in    = press_start_ff;
      last_click_in     = last_click_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (down) begin
               debounce_start_in = now_ms;
               mode_in           = MODE_DEBOUNCING;
            end
         end
         MODE_DEBOUNCING: begin
            if (debounce_passed) begin
               if (down) begin
                  press_start_in = now_ms;
                  mode_in        = MODE_PRESSED;
               end else begin
                  mode_in = MODE_IDLE;
               end
            end
         end
         MODE_PRESSED: begin
            if (!down) begin
               // window runs from the first click of a series
               if (window_passed) begin
                  click_counter_in = COUNT_BITS'(1);
                  last_click_in    = now_ms;
               end else if (click_counter_ff < CLICK_MAX) begin
                  click_counter_in = click_counter_ff + COUNT_BITS'(1);
               end
               mode_in = MODE_CLICKED;
            end else if (long_passed) begin
               mode_in = MODE_LONG;
            end
         end
         MODE_CLICKED:  mode_in = MODE_RELEASED;
         MODE_RELEASED: mode_in = MODE_IDLE;
         MODE_LONG: begin
            if (!down) begin
               press_start_in = '0;
               mode_in        = MODE_RELEASED;
            end
         end
         default: mode_in = MODE_IDLE;
      endcase
   end

   // event flags from the updated state
   always_comb begin
      entered                   = (mode_in != mode_ff);
      result.click_event        = (mode_in == MODE_CLICKED);
      result.click_total        = (mode_in == MODE_CLICKED) ? click_counter_in : '0;
      result.press_event        = (mode_in == MODE_PRESSED) && entered;
      result.release_event      = (mode_in == MODE_RELEASED);
      result.long_press_event   = (mode_in == MODE_LONG) && entered;
      result.long_release_event = (mode_in == MODE_RELEASED) && (press_start_in == '0);
      result.held_now           = (mode_in == MODE_PRESSED);
      result.mode_code          = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_IDLE;
         click_counter_ff  <= '0;
         debounce_start_ff <= '0;
         press_start_ff    <= '0;
         last_click_ff     <= '0;
      end else if (advance) begin
         mode_ff           <= mode_in;
         click_counter_ff  <= click_counter_in;
         debounce_start_ff <= debounce_start_in;
         press_start_ff    <= press_start_in;
         last_click_ff     <= last_click_in;
      end
   end

endmodule

@@ hdl/button_click_classifier.sv @@
// button click classifier top level: input register, state machine, result register
// an accepted poll waits in the input register, and its result is then taken into the
// result register, from which it is offered on rsp
// throughput: one poll per cycle; the input register is only held while the
// result register is full and rsp_tready is low
// reset: synchronous, active high; clears both registers' valid, the state
// machine to idle and the timers and count to zero; config to its defaults
// depends on bcc_pkg, bcc_csr, bcc_core

module button_click_classifier
   import bcc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // pin_level, now_ms
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // click_event, click_total, press_event, release_event, long_press_event,
   // long_release_event, held_now, mode_code
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DELAY_BITS-1:0]     csr_data
);

   bcc_cfg_type          cfg;
   bcc_result_type       result;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_pin_ff;
   logic [NOW_BITS-1:0]  in_now_ff;
   logic [TIME_BITS-1:0] now_time;
   logic                 rsp_valid_ff, rsp_valid_in;
   bcc_result_type       rsp_data_ff;
   logic                 advance;
   logic                 req_fire;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // timestamps live modulo 2^TIME_BITS
   generate
      if (TIME_BITS <= NOW_BITS) begin : g_now_trunc
         assign now_time = in_now_ff[TIME_BITS-1:0];
      end else begin : g_now_ext
         assign now_time = {{(TIME_BITS-NOW_BITS){1'b0}}, in_now_ff};
      end
   endgenerate

   bcc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pin_level (in_pin_ff),
      .now_ms    (now_time),
      .cfg       (cfg),
      .result    (result)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign req_fire     = req_tvalid && req_tready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_pin_ff <= req_tdata[0];
         in_now_ff <= req_tdata[NOW_BITS:1];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS-$bits(bcc_result_type)){1'b0}}, rsp_data_ff};

endmodule

@@ hdl/bcc_checker.sv @@
// port-level checks for the button click classifier, bound to the top level
// depends on bcc_pkg

module bcc_checker
   import bcc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_TDATA_BITS-1:0] rsp_tdata
);

   bcc_result_type r;
   assign r = rsp_tdata[$bits(bcc_result_type)-1:0];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_click_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !r.click_event |-> r.click_total == '0)
      else $error("click total outside a click");

   // flags agree with the reported mode
   a_flags_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (r.held_now == (r.mode_code == MODE_PRESSED)) &&
         (r.release_event == (r.mode_code == MODE_RELEASED)) &&
         (r.click_event == (r.mode_code == MODE_CLICKED)) &&
         (!r.press_event || r.held_now) &&
         (!r.long_release_event || r.release_event) &&
         (!r.long_press_event || r.mode_code == MODE_LONG))
      else $error("event flags disagree with mode");

   a_click_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r.click_event |-> r.click_total != '0)
      else $error("click with zero count");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/click_result_checker.sv @@
`timescale 1ns / 1ps
// checker for the button click classifier: tracks the config channel, predicts
// the flags, click total and mode of every accepted poll and compares them with each rsp transaction
// depends on bcc_pkg

module click_result_checker
   import bcc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DELAY_BITS-1:0]     csr_data,
   output int                        errors,
   output int                        pending,
   output int                        checked,
   output int                        clicks_seen,
   output int                        long_presses_seen,
   output int                        deepest_click
);

   bcc_cfg_type           cfg;
   bcc_mode_type          mode_q;
   logic [COUNT_BITS-1:0] click_count;
   logic [NOW_BITS-1:0]   debounce_t0;
   logic [NOW_BITS-1:0]   press_t0;
   logic [NOW_BITS-1:0]   last_click_t;

   bcc_result_type predicted_flags[$];

   initial begin
      errors            = 0;
      pending           = 0;
      checked           = 0;
      clicks_seen       = 0;
      long_presses_seen = 0;
      deepest_click     = 0;
   end

   // wrapping difference, strictly greater than the delay
   function automatic logic elapsed_over(input logic [NOW_BITS-1:0] now,
                                         input logic [NOW_BITS-1:0] since,
                                         input logic [DELAY_BITS-1:0] delay);
      logic [NOW_BITS-1:0] diff;
      diff = now - since;
      return diff > NOW_BITS'(delay);
   endfunction

   function automatic bcc_result_type classify_poll(input logic pin,
                                                    input logic [NOW_BITS-1:0] now);
      logic           down;
      bcc_mode_type   next_mode;
      bcc_result_type r;
      down      = (pin == cfg.active_level);
      next_mode = mode_q;
      case (mode_q)
         MODE_IDLE: begin
            if (down) begin
               debounce_t0 = now;
               next_mode   = MODE_DEBOUNCING;
            end
         end
         MODE_DEBOUNCING: begin
            if (elapsed_over(now, debounce_t0, cfg.debounce_ms)) begin
               if (down) begin
                  press_t0  = now;
                  next_mode = MODE_PRESSED;
               end else begin
                  next_mode = MODE_IDLE;
               end
            end
         end
         MODE_PRESSED: begin
            if (!down) begin
               // the window runs from the first click of a series
               if (elapsed_over(now, last_click_t, cfg.click_window_ms)) begin
                  click_count  = COUNT_BITS'(1);
                  last_click_t = now;
               end else if (click_count != CLICK_MAX) begin
                  click_count = click_count + 1'b1;
               end
               next_mode = MODE_CLICKED;
            end else if (elapsed_over(now, press_t0, cfg.long_press_ms)) begin
               next_mode = MODE_LONG;
            end
         end
         MODE_CLICKED:  next_mode = MODE_RELEASED;
         MODE_RELEASED: next_mode = MODE_IDLE;
         MODE_LONG: begin
            if (!down) begin
               press_t0  = '0;
               next_mode = MODE_RELEASED;
            end
         end
         default: next_mode = MODE_IDLE;
      endcase
      r                    = '0;
      r.click_event        = (next_mode == MODE_CLICKED);
      r.click_total        = r.click_event ? click_count : '0;
      r.press_event        = (next_mode == MODE_PRESSED) && (next_mode != mode_q);
      r.release_event      = (next_mode == MODE_RELEASED);
      r.long_press_event   = (next_mode == MODE_LONG) && (next_mode != mode_q);
      r.long_release_event = (next_mode == MODE_RELEASED) && (press_t0 == '0);
      r.held_now           = (next_mode == MODE_PRESSED);
      r.mode_code          = next_mode;
      mode_q               = next_mode;
      return r;
   endfunction

   function automatic void flag_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin : watch
      bcc_result_type got;
      bcc_result_type want;
      if (reset) begin
         cfg          = '{ACTIVE_LEVEL_RESET, DEBOUNCE_RESET, CLICK_WINDOW_RESET,
                          LONG_PRESS_RESET};
         mode_q       = MODE_IDLE;
         click_count  = '0;
         debounce_t0  = '0;
         press_t0     = '0;
         last_click_t = '0;
         predicted_flags.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = bcc_result_type'(rsp_tdata[$bits(bcc_result_type)-1:0]);
            checked++;
            if (predicted_flags.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got %h", $time, got);
            end else begin
               want = predicted_flags.pop_front();
               if (got.click_event !== want.click_event)
                  flag_field("click_event", want.click_event, got.click_event);
               if (got.click_total !== want.click_total)
                  flag_field("click_total", want.click_total, got.click_total);
               if (got.press_event !== want.press_event)
                  flag_field("press_event", want.press_event, got.press_event);
               if (got.release_event !== want.release_event)
                  flag_field("release_event", want.release_event, got.release_event);
               if (got.long_press_event !== want.long_press_event)
                  flag_field("long_press_event", want.long_press_event,
                             got.long_press_event);
               if (got.long_release_event !== want.long_release_event)
                  flag_field("long_release_event", want.long_release_event,
                             got.long_release_event);
               if (got.held_now !== want.held_now)
                  flag_field("held_now", want.held_now, got.held_now);
               if (got.mode_code !== want.mode_code)
                  flag_field("mode_code", want.mode_code, got.mode_code);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACTIVE_LEVEL: cfg.active_level    = csr_data[0];
               CSR_DEBOUNCE:     cfg.debounce_ms     = csr_data;
               CSR_CLICK_WINDOW: cfg.click_window_ms = csr_data;
               CSR_LONG_PRESS:   cfg.long_press_ms   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = classify_poll(req_tdata[0], req_tdata[NOW_BITS:1]);
            predicted_flags.push_back(want);
            if (want.click_event) begin
               clicks_seen++;
               if (int'(want.click_total) > deepest_click)
                  deepest_click = want.click_total;
            end
            if (want.long_press_event) long_presses_seen++;
         end
      end
      pending = predicted_flags.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// top of the button click classifier testbench: clock, reset, poll and config
// stimulus, a randomly stalling result sink and the final verdict
// depends on bcc_pkg, button_click_classifier and click_result_checker

module testbench;
   import bcc_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int DRAIN_CYCLES    = 4;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int PHASE_POLLS     = 55;
   localparam int SERIES_CLICKS   = 16;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;   // pin_level, now_ms
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // click_event, click_total, press_event, release_event, long_press_event,
   // long_release_event, held_now, mode_code
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DELAY_BITS-1:0]     csr_data;

   int errors;
   int pending;
   int checked;
   int clicks_seen;
   int long_presses_seen;
   int deepest_click;

   bcc_cfg_type         settings;
   logic [NOW_BITS-1:0] stamp_ms;
   int                  polls_sent    = 0;
   int                  setting_loads = 0;
   int                  cycle_count   = 0;
   logic                steady_send   = 1'b0;
   logic                hold_off_req  = 1'b0;

   button_click_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   click_result_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .errors            (errors),
      .pending           (pending),
      .checked           (checked),
      .clicks_seen       (clicks_seen),
      .long_presses_seen (long_presses_seen),
      .deepest_click     (deepest_click)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result sink: short and long random stalls, quiet stretches, and one long hold-off on request
   initial begin : rsp_sink
      int   stall_left;
      logic sink_steady;
      stall_left  = 0;
      sink_steady = 1'b0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && !sink_steady && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int idle_gap();
      int roll;
      if (steady_send) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called at a falling edge; valid stays high into the next poll when there is no gap
   task automatic send_poll(input logic pin, input logic [NOW_BITS-1:0] now);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'({now, pin});
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      polls_sent++;
   endtask

   task automatic poll_after(input logic pin, input logic [NOW_BITS-1:0] delta);
      stamp_ms = stamp_ms + delta;
      send_poll(pin, stamp_ms);
   endtask

   task automatic advance_poll(input logic pin, input int span);
      if ($urandom_range(0, 19) == 0)
         poll_after(pin, $urandom_range(0, 8 * span));
      else
         poll_after(pin, $urandom_range(0, span));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic load_settings(input bcc_cfg_type c);
      logic [CSR_INDEX_BITS-1:0] order [4];
      order = '{CSR_ACTIVE_LEVEL, CSR_DEBOUNCE, CSR_CLICK_WINDOW, CSR_LONG_PRESS};
      foreach (order[i]) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         case (order[i])
            CSR_ACTIVE_LEVEL: csr_data <= DELAY_BITS'(c.active_level);
            CSR_DEBOUNCE:     csr_data <= c.debounce_ms;
            CSR_CLICK_WINDOW: csr_data <= c.click_window_ms;
            default:          csr_data <= c.long_press_ms;
         endcase
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings = c;
      setting_loads++;
   endtask

   // mostly press/release gestures timed around one of the delays, some noise
   task automatic run_gestures(input int polls);
      int   sent;
      int   span;
      int   presses;
      int   rests;
      logic lvl;
      sent = 0;
      while (sent < polls) begin
         case ($urandom_range(0, 2))
            0:       span = settings.debounce_ms;
            1:       span = settings.click_window_ms;
            default: span = settings.long_press_ms;
         endcase
         span = span / 3 + 1;
         if ($urandom_range(0, 15) == 0) steady_send = !steady_send;
         if ($urandom_range(0, 39) == 0) wait_drained();
         if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 7) == 0) stamp_ms = $urandom;
            advance_poll($urandom_range(0, 1), span);
            sent++;
         end else begin
            presses = $urandom_range(1, 10);
            rests   = $urandom_range(1, 4);
            repeat (presses) begin
               lvl = settings.active_level;
               if ($urandom_range(0, 11) == 0) lvl = !lvl;   // contact bounce
               advance_poll(lvl, span);
            end
            repeat (rests) begin
               lvl = !settings.active_level;
               if ($urandom_range(0, 11) == 0) lvl = !lvl;
               advance_poll(lvl, span);
            end
            sent += presses + rests;
         end
      end
   endtask

   task automatic random_phase(input bcc_cfg_type c, input logic [NOW_BITS-1:0] base,
                               input int polls, input logic hold_off);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      load_settings(c);
      stamp_ms = base;
      if (hold_off) begin
         steady_send  = 1'b1;
         hold_off_req = 1'b1;
      end
      run_gestures(polls);
   endtask

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ACTIVE_LEVEL;
      csr_data   = '0;
      stamp_ms   = '0;
      settings   = '{ACTIVE_LEVEL_RESET, DEBOUNCE_RESET, CLICK_WINDOW_RESET,
                     LONG_PRESS_RESET};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: active high, debounce 2, window 10, long press 5
      load_settings(bcc_cfg_type'{1'b1, 16'd2, 16'd10, 16'd5});
      send_poll(1'b0, 32'hFFFF_FFFF);
      send_poll(1'b1, 32'hFFFF_FFFD);
      send_poll(1'b1, 32'hFFFF_FFFF);   // elapsed equals debounce, not yet
      send_poll(1'b1, 32'd0);           // pressed across the wrap, press starts at zero
      send_poll(1'b0, 32'd1);
      send_poll(1'b0, 32'd2);           // normal release still marked as long release
      send_poll(1'b0, 32'd3);
      send_poll(1'b1, 32'd4);
      send_poll(1'b1, 32'd7);
      send_poll(1'b0, 32'd8);           // double click
      send_poll(1'b0, 32'd9);
      send_poll(1'b0, 32'd10);
      send_poll(1'b1, 32'd11);
      send_poll(1'b1, 32'd14);
      send_poll(1'b0, 32'd15);          // outside the window: new series
      send_poll(1'b0, 32'd16);
      send_poll(1'b0, 32'd17);
      send_poll(1'b1, 32'd18);
      send_poll(1'b1, 32'd21);
      send_poll(1'b1, 32'd26);          // held exactly the long-press time
      send_poll(1'b1, 32'd27);          // long press
      send_poll(1'b0, 32'd29);          // release after long press
      send_poll(1'b0, 32'd30);
      send_poll(1'b1, 32'd31);
      send_poll(1'b0, 32'd34);          // bounce back to idle

      random_phase(bcc_cfg_type'{1'b0, 16'd50, 16'd300, 16'd1000}, $urandom,
                   PHASE_POLLS, 1'b0);
      random_phase(bcc_cfg_type'{1'b1, 16'd0, 16'd0, 16'd0}, $urandom,
                   PHASE_POLLS, 1'b0);
      random_phase(bcc_cfg_type'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                   32'hFFFE_0000 + $urandom_range(0, 32'hFFFF), PHASE_POLLS, 1'b0);
      random_phase(bcc_cfg_type'{1'($urandom_range(0, 1)), 16'($urandom_range(0, 30)),
                                 16'($urandom_range(0, 200)), 16'($urandom_range(0, 400))},
                   $urandom, PHASE_POLLS, 1'b1);
      random_phase(bcc_cfg_type'{1'($urandom_range(0, 1)), 16'($urandom),
                                 16'($urandom), 16'($urandom)},
                   $urandom, PHASE_POLLS, 1'b0);

      // quick click series within one window to build up a deep count
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      load_settings(bcc_cfg_type'{1'b1, 16'd0, 16'hFFFF, 16'hFFFF});
      steady_send = 1'b0;
      repeat (SERIES_CLICKS) begin
         poll_after(1'b1, 32'd1);
         poll_after(1'b1, 32'd1);
         poll_after(1'b0, 32'd1);
         poll_after(1'b0, 32'd1);
         poll_after(1'b0, 32'd1);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d polls under %0d register settings, %0d results checked",
               polls_sent, setting_loads, checked);
      $display("%0d click events (deepest count %0d), %0d long presses",
               clicks_seen, deepest_click, long_presses_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ button_click_classifier.f @@
hdl/bcc_pkg.sv
hdl/bcc_csr.sv
hdl/bcc_core.sv
hdl/button_click_classifier.sv
hdl/bcc_checker.sv
tb/sv/click_result_checker.sv
tb/sv/testbench.sv
